FILE: sv/sap_pkg.sv
// shared types and constants for the shelf atlas packer
package sap_pkg;

    localparam int SideW   = 13;
    localparam int PadW    = 4;
    localparam int SizeW   = 14;
    localparam int SumW    = 15;
    localparam int CoordW  = 12;

    localparam int InitialSideDef = 512;
    localparam int MaxSideDef     = 4096;

    localparam logic [PadW-1:0] PadReset = 4'd1;

    localparam int InDataW  = 32;
    localparam int OutDataW = 56;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CUR_X,
        ST_CUR_Y,
        ST_NEXT_Y,
        ST_NEW_Y,
        ST_NEW_X,
        ST_GROW,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [SizeW-1:0] a;
        logic [SizeW-1:0] b;
        logic [SideW-1:0] lim;
    } fit_req_t;

    typedef struct packed {
        logic [SumW-1:0] sum;
        logic            le;
    } fit_rsp_t;

endpackage

FILE: sv/sap_fit_unit.sv
// shared add and compare unit: sum of two operands and whether it fits a limit
module sap_fit_unit
(
    input  sap_pkg::fit_req_t req,
    output sap_pkg::fit_rsp_t rsp
);

    logic [sap_pkg::SumW-1:0] sum;

    assign sum     = {1'b0, req.a} + {1'b0, req.b};
    assign rsp.sum = sum;
    assign rsp.le  = sum <= {2'b00, req.lim};

endmodule

FILE: sv/shelf_atlas_packer_top.sv
// shelf atlas packer: sequencer around one shared add and compare unit
// sequence: a current-shelf hit runs CUR_X, CUR_Y, DONE; else NEXT_Y, NEW_Y, NEW_X open
//   a new shelf, and each atlas doubling adds a GROW step and a retry from NEW_Y
// one item at a time: input taken only in idle; DONE waits while the last result beat is not yet taken
// reset: rst_n asynchronous, active low; pad_size to 1, atlas sides to INITIAL_SIDE,
//   shelves empty, no result beat pending
module shelf_atlas_packer_top #(
    parameter int INITIAL_SIDE = sap_pkg::InitialSideDef,
    parameter int MAX_SIDE     = sap_pkg::MaxSideDef
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration: pad_size
    input  logic                          cfg_wr_en,
    input  logic [sap_pkg::PadW-1:0]      cfg_wr_data,
    // request stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [sap_pkg::InDataW-1:0]   s_axis_tdata,   // rect_width[12:0], rect_height[25:13]
    input  logic                          s_axis_tuser,   // fresh_atlas
    // result stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [sap_pkg::OutDataW-1:0]  m_axis_tdata,   // place_x, place_y, atlas width,
                                                          // used_rows, from bit 0 up
    output logic                          m_axis_tuser    // placed
);

    localparam int SW = sap_pkg::SideW;
    localparam int ZW = sap_pkg::SizeW;

    // side limits as 13-bit values (a side of 4096 still fits)
    localparam logic [SW-1:0] InitSide = SW'(INITIAL_SIDE);
    localparam logic [SW-1:0] MaxSide  = SW'(MAX_SIDE);

    // control state
    sap_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // configuration and atlas state
    logic [sap_pkg::PadW-1:0] pad_reg;
    logic [SW-1:0] atlas_w_reg, atlas_w_next;
    logic [SW-1:0] atlas_h_reg, atlas_h_next;
    logic [SW-1:0] cursor_reg, cursor_next;
    logic [SW-1:0] top_reg, top_next;
    logic [SW-1:0] tall_reg, tall_next;

    // per-request working registers
    logic [ZW-1:0] pw_reg, pw_next;       // padded width
    logic [ZW-1:0] ph_reg, ph_next;       // padded height
    logic [ZW-1:0] tmp_reg, tmp_next;     // cursor plus padded width, kept for a hit
    logic [SW-1:0] ny_reg, ny_next;       // top of the would-be new shelf
    logic [SW-1:0] x_reg, x_next;
    logic [SW-1:0] y_reg, y_next;
    logic          ok_reg, ok_next;

    // result register, parts the output handshake from the sequencer
    logic          out_placed_reg, out_placed_next;
    logic [sap_pkg::CoordW-1:0] out_x_reg, out_x_next;
    logic [sap_pkg::CoordW-1:0] out_y_reg, out_y_next;
    logic [SW-1:0] out_w_reg, out_w_next;
    logic [SW-1:0] out_rows_reg, out_rows_next;

    sap_pkg::fit_req_t fit_req;
    sap_pkg::fit_rsp_t fit_rsp;

    logic in_beat;
    logic out_free;
    logic grow_w;
    logic grow_h;
    logic [SW-1:0] grown_side;
    logic [SW-1:0] in_w;
    logic [SW-1:0] in_h;

    assign in_w = s_axis_tdata[12:0];
    assign in_h = s_axis_tdata[25:13];

    assign s_axis_tready = (state_reg == sap_pkg::ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // the smaller side grows, width first on a tie; a side at the limit stays
    assign grow_w = (atlas_w_reg <= atlas_h_reg) && (atlas_w_reg < MaxSide);
    assign grow_h = !grow_w && (atlas_h_reg < MaxSide);

    // doubled side, saturated at the limit
    assign grown_side = fit_rsp.le ? fit_rsp.sum[SW-1:0] : MaxSide;

    sap_fit_unit u_fit (
        .req (fit_req),
        .rsp (fit_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sap_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = sap_pkg::ST_CUR_X;
                end
            end
            sap_pkg::ST_CUR_X:
            begin
                state_next = fit_rsp.le ? sap_pkg::ST_CUR_Y : sap_pkg::ST_NEXT_Y;
            end
            sap_pkg::ST_CUR_Y:
            begin
                state_next = fit_rsp.le ? sap_pkg::ST_DONE : sap_pkg::ST_NEXT_Y;
            end
            sap_pkg::ST_NEXT_Y:
            begin
                state_next = sap_pkg::ST_NEW_Y;
            end
            sap_pkg::ST_NEW_Y:
            begin
                state_next = fit_rsp.le ? sap_pkg::ST_NEW_X : sap_pkg::ST_GROW;
            end
            sap_pkg::ST_NEW_X:
            begin
                state_next = fit_rsp.le ? sap_pkg::ST_DONE : sap_pkg::ST_GROW;
            end
            sap_pkg::ST_GROW:
            begin
                state_next = (grow_w || grow_h) ? sap_pkg::ST_NEW_Y : sap_pkg::ST_DONE;
            end
            sap_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = sap_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sap_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and shared unit steering per state
    always_comb
    begin
        fit_req         = '0;
        atlas_w_next    = atlas_w_reg;
        atlas_h_next    = atlas_h_reg;
        cursor_next     = cursor_reg;
        top_next        = top_reg;
        tall_next       = tall_reg;
        pw_next         = pw_reg;
        ph_next         = ph_reg;
        tmp_next        = tmp_reg;
        ny_next         = ny_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        ok_next         = ok_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_placed_next = out_placed_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_w_next      = out_w_reg;
        out_rows_next   = out_rows_reg;

        case (state_reg)
            sap_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    pw_next = {1'b0, in_w} + {{(ZW-sap_pkg::PadW){1'b0}}, pad_reg};
                    ph_next = {1'b0, in_h} + {{(ZW-sap_pkg::PadW){1'b0}}, pad_reg};
                    ok_next = 1'b0;
                    x_next  = '0;
                    y_next  = '0;
                    // fresh atlas: back to the initial sides with no shelves
                    if (s_axis_tuser)
                    begin
                        atlas_w_next = InitSide;
                        atlas_h_next = InitSide;
                        cursor_next  = '0;
                        top_next     = '0;
                        tall_next    = '0;
                    end
                end
            end
            sap_pkg::ST_CUR_X:
            begin
                fit_req.a   = {1'b0, cursor_reg};
                fit_req.b   = pw_reg;
                fit_req.lim = atlas_w_reg;
                tmp_next    = fit_rsp.sum[ZW-1:0];
            end
            sap_pkg::ST_CUR_Y:
            begin
                fit_req.a   = {1'b0, top_reg};
                fit_req.b   = ph_reg;
                fit_req.lim = atlas_h_reg;
                if (fit_rsp.le)
                begin
                    // hit on the current shelf
                    ok_next     = 1'b1;
                    x_next      = cursor_reg;
                    y_next      = top_reg;
                    cursor_next = tmp_reg[SW-1:0];
                    if (ph_reg > {1'b0, tall_reg})
                    begin
                        tall_next = ph_reg[SW-1:0];
                    end
                end
            end
            sap_pkg::ST_NEXT_Y:
            begin
                fit_req.a = {1'b0, top_reg};
                fit_req.b = {1'b0, tall_reg};
                ny_next   = fit_rsp.sum[SW-1:0];
            end
            sap_pkg::ST_NEW_Y:
            begin
                fit_req.a   = {1'b0, ny_reg};
                fit_req.b   = ph_reg;
                fit_req.lim = atlas_h_reg;
            end
            sap_pkg::ST_NEW_X:
            begin
                fit_req.a   = pw_reg;
                fit_req.lim = atlas_w_reg;
                if (fit_rsp.le)
                begin
                    // open a new shelf below the current one
                    ok_next     = 1'b1;
                    x_next      = '0;
                    y_next      = ny_reg;
                    cursor_next = pw_reg[SW-1:0];
                    top_next    = ny_reg;
                    tall_next   = ph_reg[SW-1:0];
                end
            end
            sap_pkg::ST_GROW:
            begin
                fit_req.lim = MaxSide;
                if (grow_w)
                begin
                    fit_req.a    = {1'b0, atlas_w_reg};
                    fit_req.b    = {1'b0, atlas_w_reg};
                    atlas_w_next = grown_side;
                end
                else if (grow_h)
                begin
                    fit_req.a    = {1'b0, atlas_h_reg};
                    fit_req.b    = {1'b0, atlas_h_reg};
                    atlas_h_next = grown_side;
                end
            end
            sap_pkg::ST_DONE:
            begin
                // used rows come from the shared unit as the beat is loaded
                fit_req.a = {1'b0, top_reg};
                fit_req.b = {1'b0, tall_reg};
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_placed_next = ok_reg;
                    out_x_next      = x_reg[sap_pkg::CoordW-1:0];
                    out_y_next      = y_reg[sap_pkg::CoordW-1:0];
                    out_w_next      = atlas_w_reg;
                    out_rows_next   = fit_rsp.sum[SW-1:0];
                end
            end
            default:
            begin
                fit_req = '0;
            end
        endcase
    end

    // control and atlas state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sap_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pad_reg       <= sap_pkg::PadReset;
            atlas_w_reg   <= InitSide;
            atlas_h_reg   <= InitSide;
            cursor_reg    <= '0;
            top_reg       <= '0;
            tall_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pad_reg <= cfg_wr_data;
            end
            atlas_w_reg   <= atlas_w_next;
            atlas_h_reg   <= atlas_h_next;
            cursor_reg    <= cursor_next;
            top_reg       <= top_next;
            tall_reg      <= tall_next;
        end
    end

    // working and result payload, no reset needed
    always_ff @(posedge clk)
    begin
        pw_reg         <= pw_next;
        ph_reg         <= ph_next;
        tmp_reg        <= tmp_next;
        ny_reg         <= ny_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        ok_reg         <= ok_next;
        out_placed_reg <= out_placed_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_w_reg      <= out_w_next;
        out_rows_reg   <= out_rows_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_placed_reg;
    assign m_axis_tdata  = {6'd0, out_rows_reg, out_w_reg, out_y_reg, out_x_reg};

endmodule

FILE: sim/testbench.sv
// self-checking testbench for the shelf atlas packer, with a predictor and paced stream traffic
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 1_000_000;
    localparam int BatchItems = 430;

    localparam int SideW          = sap_pkg::SideW;
    localparam int PadW           = sap_pkg::PadW;
    localparam int SizeW          = sap_pkg::SizeW;
    localparam int SumW           = sap_pkg::SumW;
    localparam int CoordW         = sap_pkg::CoordW;
    localparam int InDataW        = sap_pkg::InDataW;
    localparam int OutDataW       = sap_pkg::OutDataW;
    localparam int InitialSideDef = sap_pkg::InitialSideDef;
    localparam int MaxSideDef     = sap_pkg::MaxSideDef;

    // one result beat, split into its fields
    typedef struct packed {
        logic              placed;
        logic [CoordW-1:0] place_x;
        logic [CoordW-1:0] place_y;
        logic [SideW-1:0]  sheet_width;
        logic [SideW-1:0]  used_rows;
    } placement_t;

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [PadW-1:0]     cfg_wr_data   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata  = '0;   // rect_width[12:0], rect_height[25:13]
    logic                s_axis_tuser  = 1'b0; // fresh_atlas
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;         // place_x, place_y, atlas width, used_rows
    logic                m_axis_tuser;         // placed

    shelf_atlas_packer_top #(
        .INITIAL_SIDE (InitialSideDef),
        .MAX_SIDE     (MaxSideDef)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 clk = ~clk;

    // pacing of both sides, in percent of cycles
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;

    // predictor copy of the packer state
    logic [PadW-1:0]  pad_now;
    logic [SideW-1:0] sheet_w;
    logic [SideW-1:0] sheet_h;
    logic [SideW-1:0] cursor_x;
    logic [SideW-1:0] shelf_top;
    logic [SideW-1:0] shelf_tall;

    placement_t placements_due[$];
    placement_t seen;
    placement_t due;

    int n_sent    = 0;
    int n_placed  = 0;
    int n_refused = 0;
    int n_errors  = 0;
    int cycles    = 0;
    int mixed_pad = 0;

    function automatic void clear_sheet();
        sheet_w    = SideW'(InitialSideDef);
        sheet_h    = SideW'(InitialSideDef);
        cursor_x   = '0;
        shelf_top  = '0;
        shelf_tall = '0;
    endfunction

    // open a new shelf below the current one if the padded rectangle fits there
    function automatic bit open_shelf(input logic [SizeW-1:0] pw, input logic [SizeW-1:0] ph,
                                      output logic [SumW-1:0] px, output logic [SumW-1:0] py);
        logic [SumW-1:0] ny;
        ny = SumW'(shelf_top) + SumW'(shelf_tall);
        px = '0;
        py = '0;
        if (ny + SumW'(ph) <= SumW'(sheet_h) && SumW'(pw) <= SumW'(sheet_w))
        begin
            cursor_x   = SideW'(pw);
            shelf_top  = SideW'(ny);
            shelf_tall = SideW'(ph);
            py         = ny;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // place one rectangle and return the result beat it should produce
    function automatic placement_t predict_placement(input logic fresh,
                                                     input logic [SideW-1:0] w,
                                                     input logic [SideW-1:0] h);
        logic [SizeW-1:0] pw;
        logic [SizeW-1:0] ph;
        logic [SumW-1:0]  px;
        logic [SumW-1:0]  py;
        bit               ok;
        placement_t       r;
        if (fresh)
        begin
            clear_sheet();
        end
        pw = SizeW'(w) + SizeW'(pad_now);
        ph = SizeW'(h) + SizeW'(pad_now);
        px = '0;
        py = '0;
        ok = 1'b0;
        if (SumW'(cursor_x) + SumW'(pw) <= SumW'(sheet_w)
            && SumW'(shelf_top) + SumW'(ph) <= SumW'(sheet_h))
        begin
            px       = SumW'(cursor_x);
            py       = SumW'(shelf_top);
            cursor_x = SideW'(SumW'(cursor_x) + SumW'(pw));
            if (SumW'(ph) > SumW'(shelf_tall))
            begin
                shelf_tall = SideW'(ph);
            end
            ok = 1'b1;
        end
        else
        begin
            ok = open_shelf(pw, ph, px, py);
            // grow the smaller side, width first on a tie, until a shelf opens or both saturate
            while (!ok)
            begin
                if (sheet_w <= sheet_h && sheet_w < MaxSideDef)
                begin
                    sheet_w = (2 * sheet_w > MaxSideDef) ? SideW'(MaxSideDef) : SideW'(2 * sheet_w);
                end
                else if (sheet_h < MaxSideDef)
                begin
                    sheet_h = (2 * sheet_h > MaxSideDef) ? SideW'(MaxSideDef) : SideW'(2 * sheet_h);
                end
                else
                begin
                    break;
                end
                ok = open_shelf(pw, ph, px, py);
            end
        end
        r.placed      = ok;
        r.place_x     = ok ? px[CoordW-1:0] : '0;
        r.place_y     = ok ? py[CoordW-1:0] : '0;
        r.sheet_width = sheet_w;
        r.used_rows   = shelf_top + shelf_tall;
        return r;
    endfunction

    // offer one request beat, with random idle cycles before it
    task automatic send_rect(input logic fresh, input logic [SideW-1:0] w,
                             input logic [SideW-1:0] h);
        placement_t expected;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= InDataW'({h, w});
        s_axis_tuser  <= fresh;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        expected       = predict_placement(fresh, w, h);
        placements_due = {placements_due, expected};
        n_sent++;
    endtask

    // stop offering beats and let every outstanding result come back
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (placements_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pad(input logic [PadW-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        pad_now = value;
    endtask

    // runs of well-formed packing: a fresh atlas then rectangles of one scale,
    // with the odd noise beat of any size and any fresh flag
    task automatic run_random_batch(input int items);
        int               left;
        int               run_len;
        int               scale_w;
        int               scale_h;
        int               k;
        logic [SideW-1:0] w;
        logic [SideW-1:0] h;
        left = items;
        while (left > 0)
        begin
            run_len = $urandom_range(160, 8);
            case ($urandom_range(3))
                0: scale_w = 16;
                1: scale_w = 96;
                2: scale_w = 384;
                default: scale_w = 1500;
            endcase
            scale_h = ($urandom_range(3) == 0) ? $urandom_range(4096, 1) : scale_w;
            for (k = 0; k < run_len && left > 0; k++)
            begin
                if ($urandom_range(19) == 0)
                begin
                    send_rect(1'($urandom_range(1)), SideW'($urandom_range(8191)),
                              SideW'($urandom_range(8191)));
                end
                else
                begin
                    w = SideW'($urandom_range(scale_w, 1));
                    h = SideW'($urandom_range(scale_h, 1));
                    send_rect(k == 0, w, h);
                end
                left--;
            end
        end
    endtask

    // shelves, new shelves, growth, refusal and fresh atlas at the reset pad of 1
    task automatic test_directed_shelves();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_rect(1'b1, 13'd1, 13'd1);
        send_rect(1'b0, 13'd0, 13'd0);
        send_rect(1'b0, 13'd510, 13'd10);
        send_rect(1'b0, 13'd100, 13'd20);
        send_rect(1'b0, 13'd4096, 13'd4096);
        send_rect(1'b0, 13'd8191, 13'd8191);
        send_rect(1'b1, 13'd4095, 13'd4095);
        send_rect(1'b1, 13'd1, 13'd1);
        send_rect(1'b1, 13'd600, 13'd10);
        send_rect(1'b0, 13'd600, 13'd600);
        send_rect(1'b0, 13'd4096, 13'd1);
        wait_for_results();
    endtask

    // no padding: coordinates of 4096 wrap to 0; full padding at the saturated side
    task automatic test_pad_extremes();
        write_pad(4'd0);
        send_rect(1'b1, 13'd4096, 13'd4096);
        send_rect(1'b0, 13'd0, 13'd0);
        send_rect(1'b0, 13'd1, 13'd1);
        send_rect(1'b0, 13'd1, 13'd0);
        send_rect(1'b1, 13'd0, 13'd0);
        send_rect(1'b0, 13'd8191, 13'd0);
        wait_for_results();
        write_pad(4'd15);
        send_rect(1'b1, 13'd1, 13'd1);
        send_rect(1'b1, 13'd4081, 13'd4081);
        send_rect(1'b1, 13'd4082, 13'd1);
        send_rect(1'b0, 13'd0, 13'd0);
        wait_for_results();
    endtask

    task automatic test_random_steady();
        write_pad(4'd3);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        run_random_batch(BatchItems);
        wait_for_results();
    endtask

    task automatic test_random_sender_gaps();
        write_pad(4'd0);
        src_idle_pct  = 87;
        snk_stall_pct = 0;
        run_random_batch(BatchItems);
        wait_for_results();
    endtask

    task automatic test_random_receiver_stalls();
        write_pad(4'd15);
        src_idle_pct  = 0;
        snk_stall_pct = 87;
        run_random_batch(BatchItems);
        wait_for_results();
    endtask

    task automatic test_random_mixed_pacing();
        mixed_pad = $urandom_range(15);
        write_pad(PadW'(mixed_pad));
        src_idle_pct  = 16;
        snk_stall_pct = 16;
        run_random_batch(BatchItems);
        wait_for_results();
    endtask

    // receiver side: ready drops at random according to the stall rate
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // result checker: every accepted beat against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.placed      = m_axis_tuser;
            seen.place_x     = m_axis_tdata[11:0];
            seen.place_y     = m_axis_tdata[23:12];
            seen.sheet_width = m_axis_tdata[36:24];
            seen.used_rows   = m_axis_tdata[49:37];
            if (placements_due.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                begin
                    $display("%0t: unexpected beat: placed %0d x %0d y %0d w %0d rows %0d",
                             $realtime, seen.placed, seen.place_x, seen.place_y,
                             seen.sheet_width, seen.used_rows);
                end
            end
            else
            begin
                due = placements_due.pop_front();
                if (seen.placed !== due.placed || seen.place_x !== due.place_x
                    || seen.place_y !== due.place_y || seen.sheet_width !== due.sheet_width
                    || seen.used_rows !== due.used_rows)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                    begin
                        $display("%0t: mismatch, expected placed %0d x %0d y %0d w %0d rows %0d",
                                 $realtime, due.placed, due.place_x, due.place_y,
                                 due.sheet_width, due.used_rows);
                        $display("%0t:           actual placed %0d x %0d y %0d w %0d rows %0d",
                                 $realtime, seen.placed, seen.place_x, seen.place_y,
                                 seen.sheet_width, seen.used_rows);
                    end
                end
                if (due.placed)
                begin
                    n_placed++;
                end
                else
                begin
                    n_refused++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycles, placements_due.size());
        $display("status: fail");
        $finish;
    end

    initial
    begin
        pad_now = sap_pkg::PadReset;
        clear_sheet();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_shelves();
        test_pad_extremes();
        test_random_steady();
        test_random_sender_gaps();
        test_random_receiver_stalls();
        test_random_mixed_pacing();
        // allow for any stray beat after the last expected one
        repeat (100) @(posedge clk);
        if (placements_due.size() != 0)
        begin
            n_errors++;
        end
        $display("summary: %0d requests, %0d placed and %0d refused, pad sizes 0, 1, 3, 15 and %0d",
                 n_sent, n_placed, n_refused, mixed_pad);
        $display("summary: free-running, sender gaps, receiver stalls and mixed pacing; %0d errors",
                 n_errors);
        if (n_errors == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
